[rtl/core/olbi_pkg.sv]
`default_nettype none

package olbi_pkg;

  // Table geometry and field widths
  localparam int LEVELS     = 64;
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int RANK_W     = $clog2(LEVELS);
  localparam int COUNT_W    = $clog2(LEVELS + 1);
  localparam int STATUS_W   = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_JOINED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CREATED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

  // Side codes
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] limit_price;
    logic [QTY_W-1:0]   order_quantity;
  } order_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   level_rank;
    logic [QTY_W-1:0]    level_total;
  } result_t;

  // Per-cycle controls broadcast along a chain of cells
  typedef struct packed {
    logic cmp_en;
    logic add_en;
    logic shift_en;
  } cell_ctl_t;

  // Summary a chain hands back to the top level during the update cycle
  typedef struct packed {
    logic              hit;
    logic              full;
    logic [RANK_W-1:0] rank;
    logic [QTY_W-1:0]  total;
  } chain_res_t;

endpackage

`default_nettype wire

[rtl/core/olbi_cell.sv]
`default_nettype none

module olbi_cell (
  input  wire                       clk,
  input  wire                       ask_side,
  input  wire                       live,
  input  wire olbi_pkg::cell_ctl_t  ctl,
  input  wire [olbi_pkg::PRICE_W-1:0] order_price,
  input  wire [olbi_pkg::QTY_W-1:0]   order_qty,
  input  wire                       left_better,
  input  wire [olbi_pkg::PRICE_W-1:0] left_price,
  input  wire [olbi_pkg::QTY_W-1:0]   left_total,
  output logic                      better,
  output logic                      equal,
  output logic                      ins,
  output logic [olbi_pkg::PRICE_W-1:0] price,
  output logic [olbi_pkg::QTY_W-1:0]   total,
  output logic [olbi_pkg::QTY_W-1:0]   sum
);
  import olbi_pkg::*;

  logic             better_now;
  logic             equal_now;
  logic [QTY_W:0]   wide_sum;

  // A live level is better when it sorts strictly ahead of the order's price.
  always_comb begin
    if (ask_side) begin
      better_now = live && (price < order_price);
    end else begin
      better_now = live && (price > order_price);
    end
    equal_now = live && (price == order_price);
  end

  // Compare flags are captured in the compare cycle and used in the update cycle.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      better <= better_now;
      equal  <= equal_now;
    end
  end

  // This cell is the insertion point when its left neighbour is better and it is not.
  assign ins = left_better && !better;

  // Saturating total for a joining order.
  assign wide_sum = {1'b0, total} + {1'b0, order_qty};
  assign sum      = wide_sum[QTY_W] ? {QTY_W{1'b1}} : wide_sum[QTY_W-1:0];

  // Level contents: add in place, load a new level, or take the left neighbour's.
  always_ff @(posedge clk) begin
    if (ctl.add_en && equal) begin
      total <= sum;
    end else if (ctl.shift_en) begin
      if (ins) begin
        price <= order_price;
        total <= order_qty;
      end else if (!better) begin
        price <= left_price;
        total <= left_total;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/olbi_chain.sv]
`default_nettype none

module olbi_chain (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         ask_side,
  input  wire                         cmp_en,
  input  wire                         upd_en,
  input  wire [olbi_pkg::PRICE_W-1:0] order_price,
  input  wire [olbi_pkg::QTY_W-1:0]   order_qty,
  output olbi_pkg::chain_res_t        res
);
  import olbi_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [LEVELS-1:0]  better;
  logic [LEVELS-1:0]  equal;
  logic [LEVELS-1:0]  ins;
  logic [PRICE_W-1:0] prices [LEVELS];
  logic [QTY_W-1:0]   totals [LEVELS];
  logic [QTY_W-1:0]   sums   [LEVELS];
  logic               hit;
  logic               full;
  cell_ctl_t          ctl;

  assign hit  = |equal;
  assign full = (count == COUNT_W'(LEVELS));

  assign ctl.cmp_en   = cmp_en;
  assign ctl.add_en   = upd_en && hit;
  assign ctl.shift_en = upd_en && !hit && !full;

  // Row of level cells, each but the head fed by its left neighbour.
  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic               left_better;
    logic [PRICE_W-1:0] left_price;
    logic [QTY_W-1:0]   left_total;

    if (i == 0) begin : g_head
      assign left_better = 1'b1;
      assign left_price  = '0;
      assign left_total  = '0;
    end else begin : g_body
      assign left_better = better[i-1];
      assign left_price  = prices[i-1];
      assign left_total  = totals[i-1];
    end

    olbi_cell u_cell (
      .clk         (clk),
      .ask_side    (ask_side),
      .live        (COUNT_W'(i) < count),
      .ctl         (ctl),
      .order_price (order_price),
      .order_qty   (order_qty),
      .left_better (left_better),
      .left_price  (left_price),
      .left_total  (left_total),
      .better      (better[i]),
      .equal       (equal[i]),
      .ins         (ins[i]),
      .price       (prices[i]),
      .total       (totals[i]),
      .sum         (sums[i])
    );
  end

  // Level count grows by one for every new level.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.shift_en) begin
      count <= count + COUNT_W'(1);
    end
  end

  // Encode the one-hot insertion point and select the matching level's new total.
  always_comb begin
    res.hit   = hit;
    res.full  = full;
    res.rank  = '0;
    res.total = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (ins[i]) begin
        res.rank = res.rank | RANK_W'(i);
      end
      if (equal[i]) begin
        res.total = res.total | sums[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/order_book_level_insert_core.sv]
`default_nettype none
// Each order passes through a compare state across all cells of the side's chain,
// then an update state that adds, shifts or inserts; the result is registered
// as the update fires, when a new order can also be accepted. A stalled result
// holds the update and the next order back. Reset clears both level counts and
// the handshake state; level contents are not cleared and need no clearing pass.
module order_book_level_insert_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                order_valid,
  output logic               order_ready,
  input  wire olbi_pkg::order_t order,
  output logic               result_valid,
  input  wire                result_ready,
  output olbi_pkg::result_t  result
);
  import olbi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  order_t      held;
  logic        accept;
  logic        upd_fire;
  chain_res_t  bid_res;
  chain_res_t  ask_res;
  chain_res_t  sel_res;
  result_t     result_next;

  // The update cycle fires once the output register is free to take its result.
  assign upd_fire    = (state == ST_UPD) && (!result_valid || result_ready);
  assign order_ready = (state == ST_IDLE) || upd_fire;
  assign accept      = order_valid && order_ready;

  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_CMP : ST_IDLE;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  state_next = accept ? ST_CMP : (upd_fire ? ST_IDLE : ST_UPD);
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Order is held from acceptance until its update cycle completes.
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= order;
    end
  end

  // One chain of cells per side of the book.
  olbi_chain u_bid (
    .clk         (clk),
    .rst         (rst),
    .ask_side    (SIDE_BID),
    .cmp_en      ((state == ST_CMP) && (held.side == SIDE_BID)),
    .upd_en      (upd_fire && (held.side == SIDE_BID)),
    .order_price (held.limit_price),
    .order_qty   (held.order_quantity),
    .res         (bid_res)
  );

  olbi_chain u_ask (
    .clk         (clk),
    .rst         (rst),
    .ask_side    (SIDE_ASK),
    .cmp_en      ((state == ST_CMP) && (held.side == SIDE_ASK)),
    .upd_en      (upd_fire && (held.side == SIDE_ASK)),
    .order_price (held.limit_price),
    .order_qty   (held.order_quantity),
    .res         (ask_res)
  );

  // Form the result from the chain that served the order.
  always_comb begin
    sel_res = (held.side == SIDE_ASK) ? ask_res : bid_res;
    if (sel_res.hit) begin
      result_next.status      = STATUS_JOINED;
      result_next.level_rank  = sel_res.rank;
      result_next.level_total = sel_res.total;
    end else if (sel_res.full) begin
      result_next.status      = STATUS_REJECTED;
      result_next.level_rank  = '0;
      result_next.level_total = '0;
    end else begin
      result_next.status      = STATUS_CREATED;
      result_next.level_rank  = sel_res.rank;
      result_next.level_total = held.order_quantity;
    end
  end

  // Output register decouples the result transaction from the next order.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (upd_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
